@@ rtl/core/gcml_pkg.sv @@
// gcml_pkg: shared types, constants and table reset values for the gradient color map
`timescale 1ns / 1ps
package gcml_pkg;

  localparam int unsigned MaxStops = 16;
  localparam int unsigned IdxBits  = 4;
  localparam int unsigned CntBits  = 5;
  localparam int unsigned PosBits  = 16;
  localparam int unsigned ChanBits = 8;
  localparam int unsigned ColBits  = 3 * ChanBits;
  localparam int unsigned NumBits  = PosBits + ChanBits;
  localparam int unsigned EntBits  = PosBits + ColBits;

  localparam logic [0:0] FuncWrite  = 1'b0;
  localparam logic [0:0] FuncLookup = 1'b1;

  localparam logic [CntBits-1:0] CountReset = 5'd2;
  localparam logic [CntBits-1:0] CountMax   = 5'd16;
  localparam logic [CntBits-1:0] CountMin   = 5'd2;

  localparam logic [0:0] RegStopCount = 1'b0;

  typedef enum logic [2:0] {
    StIdle,
    StLoad0,
    StScan,
    StMul,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } blend_ctl_t;

  typedef struct packed {
    logic [PosBits-1:0] pos;
    logic [ColBits-1:0] col;
  } entry_t;

  // table contents after reset: entry one is full scale white, the rest zero black
  function automatic entry_t reset_entry(input logic [IdxBits-1:0] idx);
    entry_t e;
    e.pos = '0;
    e.col = '0;
    if (idx == IdxBits'(1)) begin
      e.pos = '1;
      e.col = '1;
    end
    return e;
  endfunction

endpackage

@@ rtl/core/gcml_blend.sv @@
// gcml_blend: one color channel, weighted sum and 8-step restoring division
`timescale 1ns / 1ps
module gcml_blend (
  input  logic                             clk_i,
  input  gcml_pkg::blend_ctl_t             ctl_i,
  input  logic [gcml_pkg::PosBits-1:0]     d_i,
  input  logic [gcml_pkg::PosBits-1:0]     len_i,
  input  logic [gcml_pkg::ChanBits-1:0]    c_lo_i,
  input  logic [gcml_pkg::ChanBits-1:0]    c_hi_i,
  output logic [gcml_pkg::ChanBits-1:0]    quot_o
);

  logic [gcml_pkg::NumBits-1:0]  p_hi, p_lo, num_init;
  logic [gcml_pkg::NumBits-1:0]  num_q, num_d;
  logic [gcml_pkg::NumBits-1:0]  den_q, den_d;
  logic [gcml_pkg::ChanBits-1:0] quot_q, quot_d;
  logic                          ge;

  assign p_hi     = {{gcml_pkg::ChanBits{1'b0}}, d_i} *
                    {{gcml_pkg::PosBits{1'b0}}, c_hi_i};
  assign p_lo     = {{gcml_pkg::ChanBits{1'b0}}, (len_i - d_i)} *
                    {{gcml_pkg::PosBits{1'b0}}, c_lo_i};
  assign num_init = p_hi + p_lo;
  assign ge       = (num_q >= den_q);

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (ctl_i.load) begin
      num_d  = num_init;
      den_d  = {1'b0, len_i, {(gcml_pkg::ChanBits-1){1'b0}}};
      quot_d = '0;
    end else if (ctl_i.step) begin
      if (ge) begin
        num_d = num_q - den_q;
      end
      den_d  = den_q >> 1;
      quot_d = {quot_q[gcml_pkg::ChanBits-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

@@ rtl/core/gradient_color_map_lookup.sv @@
// gradient_color_map_lookup: stop table memory, segment scan and channel blend
`timescale 1ns / 1ps
// A write word (func 0) stores one stop into the 16-entry table and gives no result. A
// lookup word (func 1) reads the table one entry per cycle through its single synchronous
// read port: it fetches entry zero, tests one segment per entry read (up to 15), then, for
// a position strictly inside a segment, multiplies and runs restoring division for the three
// channels in parallel, and loads the output register; with stop_count below two it skips
// the scan. The load waits until the previous result has been taken. The result sits in
// the output register while the next word is taken. stop_count is written at byte address
// 0 of the APB port; values above 16 act as 16.
module gradient_color_map_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [gcml_pkg::IdxBits-1:0]  stop_index_i,
  input  logic [gcml_pkg::PosBits-1:0]  stop_position_i,
  input  logic [gcml_pkg::ChanBits-1:0] stop_red_i,
  input  logic [gcml_pkg::ChanBits-1:0] stop_green_i,
  input  logic [gcml_pkg::ChanBits-1:0] stop_blue_i,
  input  logic [gcml_pkg::PosBits-1:0]  query_position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gcml_pkg::ChanBits-1:0] out_red_o,
  output logic [gcml_pkg::ChanBits-1:0] out_green_o,
  output logic [gcml_pkg::ChanBits-1:0] out_blue_o,
  output logic                          in_range_o
);

  localparam int unsigned CB = gcml_pkg::ChanBits;

  gcml_pkg::state_e state_q, state_d;

  logic [gcml_pkg::CntBits-1:0] stop_count_q;
  logic                         cfg_wr;

  gcml_pkg::entry_t                mem_q [gcml_pkg::MaxStops];
  logic [gcml_pkg::MaxStops-1:0]   vld_q;
  gcml_pkg::entry_t                rd_data_q;
  logic                            rd_vld_q;
  logic [gcml_pkg::IdxBits-1:0]    rd_idx_q;
  logic                            rd_en;
  logic [gcml_pkg::IdxBits-1:0]    rd_addr;
  gcml_pkg::entry_t                ent;

  logic                            acc, acc_wr, acc_lk;
  logic [gcml_pkg::PosBits-1:0]    q_q;
  logic [gcml_pkg::CntBits-1:0]    cnt_q;
  logic [gcml_pkg::IdxBits-1:0]    idx_q;
  gcml_pkg::entry_t                prev_q;
  logic [gcml_pkg::ColBits-1:0]    first_col_q;
  logic [gcml_pkg::ColBits-1:0]    res_col_q;
  logic                            res_hit_q;
  logic                            sel_div_q;
  logic [gcml_pkg::PosBits-1:0]    d_q, len_q;
  logic [gcml_pkg::ColBits-1:0]    lo_col_q, hi_col_q;
  logic [2:0]                      div_cnt_q;

  logic                            hit_lo, hit_hi, in_seg, more;
  logic                            out_load;
  gcml_pkg::blend_ctl_t            bctl;
  logic [CB-1:0]                   q_red, q_green, q_blue;

  logic                            out_valid_q;
  logic [gcml_pkg::ColBits-1:0]    out_col_q;
  logic                            out_hit_q;

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == gcml_pkg::RegStopCount) ?
                  {{(32-gcml_pkg::CntBits){1'b0}}, stop_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= gcml_pkg::CountReset;
    end else if (cfg_wr && paddr[2] == gcml_pkg::RegStopCount) begin
      stop_count_q <= pwdata[gcml_pkg::CntBits-1:0];
    end
  end

  // input handshake
  assign in_ready_o = (state_q == gcml_pkg::StIdle);
  assign acc        = in_valid_i & in_ready_o;
  assign acc_wr     = acc & (func_i == gcml_pkg::FuncWrite);
  assign acc_lk     = acc & (func_i == gcml_pkg::FuncLookup);

  // stop table
  always_ff @(posedge clk_i) begin
    if (acc_wr) begin
      mem_q[stop_index_i] <= '{pos: stop_position_i,
                               col: {stop_red_i, stop_green_i, stop_blue_i}};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (acc_wr) begin
      vld_q[stop_index_i] <= 1'b1;
    end
  end

  assign ent = rd_vld_q ? rd_data_q : gcml_pkg::reset_entry(rd_idx_q);

  // segment tests
  assign hit_lo = (prev_q.pos == q_q);
  assign hit_hi = (ent.pos == q_q);
  assign in_seg = (prev_q.pos < q_q) && (q_q < ent.pos);
  assign more   = (({1'b0, idx_q} + gcml_pkg::CntBits'(1)) < cnt_q);

  assign out_load = (state_q == gcml_pkg::StOut) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcml_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    bctl      = '0;
    case (state_q)
      gcml_pkg::StIdle: begin
        if (acc_lk) begin
          rd_en   = 1'b1;
          state_d = gcml_pkg::StLoad0;
        end
      end
      gcml_pkg::StLoad0: begin
        rd_en   = 1'b1;
        rd_addr = gcml_pkg::IdxBits'(1);
        state_d = (cnt_q < gcml_pkg::CountMin) ? gcml_pkg::StOut : gcml_pkg::StScan;
      end
      gcml_pkg::StScan: begin
        rd_en   = 1'b1;
        rd_addr = idx_q + gcml_pkg::IdxBits'(1);
        if (hit_lo || hit_hi) begin
          state_d = gcml_pkg::StOut;
        end else if (in_seg) begin
          state_d = gcml_pkg::StMul;
        end else if (!more) begin
          state_d = gcml_pkg::StOut;
        end
      end
      gcml_pkg::StMul: begin
        bctl.load = 1'b1;
        state_d   = gcml_pkg::StDiv;
      end
      gcml_pkg::StDiv: begin
        bctl.step = 1'b1;
        if (div_cnt_q == 3'd7) begin
          state_d = gcml_pkg::StOut;
        end
      end
      gcml_pkg::StOut: begin
        if (out_load) begin
          state_d = gcml_pkg::StIdle;
        end
      end
      default: begin
        state_d = gcml_pkg::StIdle;
      end
    endcase
  end

  // lookup datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      gcml_pkg::StIdle: begin
        if (acc_lk) begin
          q_q   <= query_position_i;
          cnt_q <= (stop_count_q > gcml_pkg::CountMax) ? gcml_pkg::CountMax : stop_count_q;
        end
      end
      gcml_pkg::StLoad0: begin
        prev_q      <= ent;
        first_col_q <= ent.col;
        idx_q       <= gcml_pkg::IdxBits'(1);
        res_col_q   <= ent.col;
        res_hit_q   <= 1'b0;
        sel_div_q   <= 1'b0;
      end
      gcml_pkg::StScan: begin
        if (hit_lo) begin
          res_col_q <= prev_q.col;
          res_hit_q <= 1'b1;
        end else if (hit_hi) begin
          res_col_q <= ent.col;
          res_hit_q <= 1'b1;
        end else if (in_seg) begin
          d_q       <= q_q - prev_q.pos;
          len_q     <= ent.pos - prev_q.pos;
          lo_col_q  <= prev_q.col;
          hi_col_q  <= ent.col;
          res_hit_q <= 1'b1;
          sel_div_q <= 1'b1;
        end else if (more) begin
          prev_q <= ent;
          idx_q  <= idx_q + gcml_pkg::IdxBits'(1);
        end else begin
          res_col_q <= first_col_q;
          res_hit_q <= 1'b0;
        end
      end
      gcml_pkg::StMul: begin
        div_cnt_q <= 3'd0;
      end
      gcml_pkg::StDiv: begin
        div_cnt_q <= div_cnt_q + 3'd1;
      end
      default: begin
      end
    endcase
  end

  gcml_blend u_blend_red (
    .clk_i  (clk_i),
    .ctl_i  (bctl),
    .d_i    (d_q),
    .len_i  (len_q),
    .c_lo_i (lo_col_q[3*CB-1:2*CB]),
    .c_hi_i (hi_col_q[3*CB-1:2*CB]),
    .quot_o (q_red)
  );

  gcml_blend u_blend_green (
    .clk_i  (clk_i),
    .ctl_i  (bctl),
    .d_i    (d_q),
    .len_i  (len_q),
    .c_lo_i (lo_col_q[2*CB-1:CB]),
    .c_hi_i (hi_col_q[2*CB-1:CB]),
    .quot_o (q_green)
  );

  gcml_blend u_blend_blue (
    .clk_i  (clk_i),
    .ctl_i  (bctl),
    .d_i    (d_q),
    .len_i  (len_q),
    .c_lo_i (lo_col_q[CB-1:0]),
    .c_hi_i (hi_col_q[CB-1:0]),
    .quot_o (q_blue)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q <= sel_div_q ? {q_red, q_green, q_blue} : res_col_q;
      out_hit_q <= res_hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_col_q[3*CB-1:2*CB];
  assign out_green_o = out_col_q[2*CB-1:CB];
  assign out_blue_o  = out_col_q[CB-1:0];
  assign in_range_o  = out_hit_q;

endmodule

@@ dv/tb.sv @@
// tb: self-checking testbench for the gradient color map lookup, queue-fed driver and monitor
`timescale 1ns / 1ps
module tb;

  localparam int unsigned MaxStops = gcml_pkg::MaxStops;
  localparam int unsigned IdxBits  = gcml_pkg::IdxBits;
  localparam int unsigned CntBits  = gcml_pkg::CntBits;
  localparam int unsigned PosBits  = gcml_pkg::PosBits;
  localparam int unsigned ChanBits = gcml_pkg::ChanBits;
  localparam int unsigned ColBits  = gcml_pkg::ColBits;

  localparam logic [0:0]         FuncWrite    = gcml_pkg::FuncWrite;
  localparam logic [0:0]         FuncLookup   = gcml_pkg::FuncLookup;
  localparam logic [0:0]         RegStopCount = gcml_pkg::RegStopCount;
  localparam logic [CntBits-1:0] CountReset   = gcml_pkg::CountReset;
  localparam logic [CntBits-1:0] CountMax     = gcml_pkg::CountMax;
  localparam logic [CntBits-1:0] CountMin     = gcml_pkg::CountMin;

  typedef struct packed {
    logic [0:0]          func;
    logic [IdxBits-1:0]  idx;
    logic [PosBits-1:0]  pos;
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
    logic [PosBits-1:0]  query;
  } lut_word_t;

  typedef struct packed {
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
    logic                hit;
  } color_res_t;

  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned IdlePct      = 11;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                psel             = 1'b0;
  logic                penable          = 1'b0;
  logic                pwrite           = 1'b0;
  logic [2:0]          paddr            = '0;
  logic [31:0]         pwdata           = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic                func_i           = 1'b0;
  logic [IdxBits-1:0]  stop_index_i     = '0;
  logic [PosBits-1:0]  stop_position_i  = '0;
  logic [ChanBits-1:0] stop_red_i       = '0;
  logic [ChanBits-1:0] stop_green_i     = '0;
  logic [ChanBits-1:0] stop_blue_i      = '0;
  logic [PosBits-1:0]  query_position_i = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [ChanBits-1:0] out_red_o;
  logic [ChanBits-1:0] out_green_o;
  logic [ChanBits-1:0] out_blue_o;
  logic                in_range_o;

  gradient_color_map_lookup i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .stop_index_i     (stop_index_i),
    .stop_position_i  (stop_position_i),
    .stop_red_i       (stop_red_i),
    .stop_green_i     (stop_green_i),
    .stop_blue_i      (stop_blue_i),
    .query_position_i (query_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o),
    .in_range_o       (in_range_o)
  );

  logic [PosBits-1:0] tbl_pos [MaxStops];
  logic [ColBits-1:0] tbl_col [MaxStops];
  logic [CntBits-1:0] cfg_count;

  lut_word_t   lut_word_q [$];
  color_res_t  want_color_q [$];
  lut_word_t   cur_word;
  color_res_t  want;
  logic        word_busy = 1'b0;
  logic        calm      = 1'b0;
  logic        hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned err_cnt   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void send_word(input lut_word_t w);
    lut_word_q.insert(lut_word_q.size(), w);
  endfunction

  function automatic void queue_color(input color_res_t r);
    want_color_q.insert(want_color_q.size(), r);
  endfunction

  function automatic logic [ChanBits-1:0] mix_chan(input int unsigned d, input int unsigned len,
                                                   input logic [ChanBits-1:0] lo,
                                                   input logic [ChanBits-1:0] hi);
    int unsigned acc;
    acc = d * hi + (len - d) * lo;
    return ChanBits'(acc / len);
  endfunction

  function automatic color_res_t map_color(input logic [PosBits-1:0] q);
    int unsigned n;
    int unsigned lim;
    logic found;
    logic [PosBits-1:0] p1;
    logic [PosBits-1:0] p2;
    logic [ColBits-1:0] c1;
    logic [ColBits-1:0] c2;
    color_res_t r;
    lim = (cfg_count > CountMax) ? CountMax : cfg_count;
    r = {tbl_col[0], 1'b0};
    found = 1'b0;
    for (n = 1; n < lim && !found; n++) begin
      p1 = tbl_pos[n-1];
      p2 = tbl_pos[n];
      c1 = tbl_col[n-1];
      c2 = tbl_col[n];
      if (p1 == q) begin
        r = {c1, 1'b1};
        found = 1'b1;
      end else if (p2 == q) begin
        r = {c2, 1'b1};
        found = 1'b1;
      end else if (p1 < q && q < p2) begin
        r.red   = mix_chan(q - p1, p2 - p1, c1[2*ChanBits +: ChanBits],
                           c2[2*ChanBits +: ChanBits]);
        r.green = mix_chan(q - p1, p2 - p1, c1[ChanBits +: ChanBits],
                           c2[ChanBits +: ChanBits]);
        r.blue  = mix_chan(q - p1, p2 - p1, c1[0 +: ChanBits], c2[0 +: ChanBits]);
        r.hit   = 1'b1;
        found   = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic lut_word_t stop_word(input int unsigned idx, input int unsigned pos,
                                          input logic [ColBits-1:0] col);
    lut_word_t w;
    w.func  = FuncWrite;
    w.idx   = IdxBits'(idx);
    w.pos   = PosBits'(pos);
    {w.red, w.green, w.blue} = col;
    w.query = PosBits'($urandom);
    return w;
  endfunction

  function automatic lut_word_t query_word(input int unsigned q);
    lut_word_t w;
    w.func  = FuncLookup;
    w.idx   = IdxBits'($urandom);
    w.pos   = PosBits'($urandom);
    w.red   = ChanBits'($urandom);
    w.green = ChanBits'($urandom);
    w.blue  = ChanBits'($urandom);
    w.query = PosBits'(q);
    return w;
  endfunction

  task automatic check_field(input string name, input logic [ChanBits-1:0] want_v,
                             input logic [ChanBits-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      err_cnt++;
    end
  endtask

  // input word driver
  always @(negedge clk_i) begin
    if (rst_ni && !word_busy) begin
      if (lut_word_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        cur_word = lut_word_q.pop_front();
        word_busy = 1'b1;
        in_valid_i       <= 1'b1;
        func_i           <= cur_word.func;
        stop_index_i     <= cur_word.idx;
        stop_position_i  <= cur_word.pos;
        stop_red_i       <= cur_word.red;
        stop_green_i     <= cur_word.green;
        stop_blue_i      <= cur_word.blue;
        query_position_i <= cur_word.query;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // accepted words update the table or queue a color
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (cur_word.func == FuncLookup) begin
        queue_color(map_color(cur_word.query));
      end else begin
        tbl_pos[cur_word.idx] = cur_word.pos;
        tbl_col[cur_word.idx] = {cur_word.red, cur_word.green, cur_word.blue};
      end
      word_busy = 1'b0;
    end
  end

  // result ready with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (want_color_q.size() == 0) begin
        $error("unexpected result word: red %0d green %0d blue %0d in_range %0d",
               out_red_o, out_green_o, out_blue_o, in_range_o);
        err_cnt++;
      end else begin
        want = want_color_q.pop_front();
        check_field("out_red", want.red, out_red_o);
        check_field("out_green", want.green, out_green_o);
        check_field("out_blue", want.blue, out_blue_o);
        check_field("in_range", ChanBits'(want.hit), ChanBits'(in_range_o));
      end
    end
  end

  task automatic drain();
    while (lut_word_q.size() != 0 || word_busy || want_color_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_stop_count(input logic [CntBits-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegStopCount, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_count = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[CntBits-1:0] !== val) begin
      $error("stop_count mismatch: expected %0d, actual %0d", val, prdata[CntBits-1:0]);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sorted table load followed by lookups, with table noise near the end
  task automatic random_phase(input logic [CntBits-1:0] count, input int unsigned looks);
    int unsigned n;
    int unsigned span;
    int unsigned p;
    int unsigned k;
    int unsigned pick;
    int unsigned stop_at [MaxStops];
    drain();
    write_stop_count(count);
    if (count < CountMin) n = $urandom_range(6, 2);
    else if (count > CountMax) n = MaxStops;
    else n = count;
    span = 2 * 65536 / n;
    p = ($urandom_range(3) == 0) ? 0 : $urandom_range(span);
    for (k = 0; k < n; k++) begin
      if (k == n - 1 && $urandom_range(3) == 0) p = 65535;
      if (p > 65535) p = 65535;
      stop_at[k] = p;
      send_word(stop_word(k, p, ColBits'($urandom)));
      p += $urandom_range(span);
    end
    for (k = 0; k < looks; k++) begin
      pick = $urandom_range(99);
      if (k > looks * 3 / 4 && pick < 10)
        send_word(stop_word($urandom_range(MaxStops - 1), $urandom, ColBits'($urandom)));
      else if (pick < 40)
        send_word(query_word(stop_at[$urandom_range(n - 1)]));
      else if (pick < 50)
        send_word(query_word(stop_at[$urandom_range(n - 1)] +
                             ($urandom_range(1) ? 1 : -1)));
      else if (pick < 85)
        send_word(query_word($urandom_range(stop_at[n - 1], stop_at[0])));
      else
        send_word(query_word($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < MaxStops; i++) begin
      tbl_pos[i] = '0;
      tbl_col[i] = '0;
    end
    tbl_pos[1] = '1;
    tbl_col[1] = '1;
    cfg_count  = CountReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset table: black at zero, white at full scale
    send_word(query_word(0));
    send_word(query_word(65535));
    send_word(query_word(1));
    send_word(query_word(32768));
    send_word(query_word(65534));
    send_word(stop_word(0, 100, 24'hFF0080));
    send_word(stop_word(1, 1000, 24'h00FF07));
    send_word(query_word(50));
    send_word(query_word(2000));
    send_word(query_word(100));
    send_word(query_word(1000));
    send_word(query_word(550));
    send_word(query_word(101));
    send_word(query_word(999));
    send_word(stop_word(15, 65535, 24'hFFFFFF));
    send_word(stop_word(2, 5000, 24'h102030));
    send_word(query_word(5000));
    // fewer than two stops: fallback even on the first stop position
    drain();
    write_stop_count(0);
    send_word(query_word(100));
    drain();
    write_stop_count(1);
    send_word(query_word(100));
    // full table, unsorted tail
    drain();
    write_stop_count(CountMax);
    send_word(query_word(3000));
    send_word(query_word(65535));
    send_word(query_word(0));
    // count above the table
    drain();
    write_stop_count(5'd31);
    send_word(query_word(20000));
    send_word(query_word(40000));

    random_phase(CountMax, 100);
    random_phase(CountMin, 100);
    hold_req = 1'b1;
    random_phase(5'd7, 100);
    random_phase(CountMax, 100);
    calm = 1'b1;
    random_phase(5'd31, 100);
    drain();
    calm = 1'b0;
    random_phase(5'd3, 100);
    random_phase(5'd12, 100);
    random_phase(CountMax, 100);
    random_phase(5'd1, 100);
    random_phase(5'd17, 100);
    random_phase(5'd5, 100);
    random_phase(CountMax, 100);
    drain();

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/gcml_pkg.sv
rtl/core/gcml_blend.sv
rtl/core/gradient_color_map_lookup.sv
dv/tb.sv
